[rtl/anti_replay_window_bitmap_macros.svh]
// Assertion macros for the anti-replay window checker.
// Relies on the including module having clk and an active-low rst_n in scope.
`ifndef ANTI_REPLAY_WINDOW_BITMAP_MACROS_SVH
`define ANTI_REPLAY_WINDOW_BITMAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARWB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen while out of reset.
`define ARWB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[rtl/arwb_pkg.sv]
// Shared types and constants for the anti-replay window checker.
// No dependencies; used by anti_replay_window_bitmap.
package arwb_pkg;

  // Default replay window in sequence numbers.
  localparam int WINDOW_BITS_DEFAULT = 1024;

  typedef logic [2:0] verdict_t;

  localparam verdict_t VERDICT_FIRST = 3'd0;
  localparam verdict_t VERDICT_AHEAD = 3'd1;
  localparam verdict_t VERDICT_NEW   = 3'd2;
  localparam verdict_t VERDICT_DUP   = 3'd3;
  localparam verdict_t VERDICT_OLD   = 3'd4;
  localparam verdict_t VERDICT_FAR   = 3'd5;

  // A verdict that lets the packet through.
  function automatic logic verdict_ok(verdict_t v);
    return (v == VERDICT_FIRST) || (v == VERDICT_AHEAD) || (v == VERDICT_NEW);
  endfunction

endpackage

[rtl/anti_replay_window_bitmap.sv]
// Sliding-window anti-replay checker: one word in, one verdict word out, bitmap in a RAM.
// Depends on arwb_pkg and anti_replay_window_bitmap_macros.svh.
//
// The block checks each packet sequence number against the highest number recorded so far
// and a seen-bitmap of WINDOW_BITS (rounded up to a multiple of eight) bits, kept in a
// single-port-write, registered-read RAM of eight-bit rows. A number equal to the highest is
// a duplicate; one ahead of it by up to a quarter of the window (modulo 2^16 or 2^32, as
// set by cfg_write_data when cfg_write_en is high) is accepted; one behind it by less than
// the window is accepted only if its bit is clear. With in_action high an accepted word is
// also recorded: an advance clears the bits of every number skipped and sets the new one.
// The first recorded word after reset is always accepted. After reset the block holds
// in_stall high while it sweeps the RAM to zero row by row. A word accepted after that
// passes through accept, classify, bitmap read and result, where the result register is
// loaded, when the bitmap size is a power of two; the bitmap read is skipped when the
// verdict does not need the bitmap. Otherwise the bit index is first found by a
// four-bit-per-cycle remainder unit between accept and classify. A recorded advance
// also clears the skipped numbers before the result step, walking the RAM downwards in
// chunks that each stay within one row, with read-modify-write and forwarding
// of the row just written. One word is worked on at a time; the result register lets the
// next word be accepted while a result still waits on out_stall.
module anti_replay_window_bitmap #(
  parameter int WINDOW_BITS = arwb_pkg::WINDOW_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_write_en,
  input  logic                cfg_write_data,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [31:0]         in_sequence_req,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_accepted,
  output arwb_pkg::verdict_t  out_verdict,
  output logic [31:0]         out_highest_seen
);

  `include "anti_replay_window_bitmap_macros.svh"

  // Geometry of the bitmap. Its size is the window rounded up to whole rows of eight.
  localparam int STORE_BITS = ((WINDOW_BITS + 7) / 8) * 8;
  localparam int ROWS       = STORE_BITS / 8;
  localparam int SLOT_W     = $clog2(STORE_BITS);
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FWD_MAX    = WINDOW_BITS / 4;
  localparam int CNT_W      = $clog2(FWD_MAX + 1);
  localparam bit SLOT_POW2  = (STORE_BITS == (1 << SLOT_W));
  localparam int MODX_W     = SLOT_W + 4;

  // Bit index of the largest number in each sequence width.
  localparam logic [SLOT_W-1:0] MOD_NARROW = SLOT_W'(65535 % STORE_BITS);
  localparam logic [SLOT_W-1:0] MOD_WIDE   = SLOT_W'(64'hFFFF_FFFF % STORE_BITS);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(STORE_BITS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

  // Sequencer states.
  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MOD    = 3'd2;
  localparam logic [2:0] ST_CLASS  = 3'd3;
  localparam logic [2:0] ST_LOOK   = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  // ---------------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------------
  logic [2:0]          state_r, state_nxt;
  logic                wide_r, wide_nxt;
  logic                started_r, started_nxt;
  logic [31:0]         highest_r, highest_nxt;
  logic [31:0]         vm_r, vm_nxt;          // request number, masked to the mode's width
  logic                rec_r, rec_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;      // bit index of the request number
  logic [2:0]          digit_r, digit_nxt;
  arwb_pkg::verdict_t  verdict_r, verdict_nxt;
  logic [ROW_W-1:0]    sweep_r, sweep_nxt;

  // Walker for the clearing of skipped numbers, moving downwards from the new highest.
  logic [31:0]         p_r, p_nxt;            // number at the top of the next chunk
  logic [SLOT_W-1:0]   s_r, s_nxt;            // its bit index
  logic [CNT_W-1:0]    n_r, n_nxt;            // numbers still to clear

  // Read-modify-write pipeline: a row read is issued with its op, written the next cycle.
  logic                op_v_r, op_v_nxt;
  logic [ROW_W-1:0]    op_row_r, op_row_nxt;
  logic [7:0]          op_clr_r, op_clr_nxt;
  logic [7:0]          op_set_r, op_set_nxt;
  logic                fwd_hit_r, fwd_hit_nxt;
  logic [7:0]          fwd_data_r, fwd_data_nxt;

  logic                out_valid_r;
  logic                out_accepted_r;
  arwb_pkg::verdict_t  out_verdict_r;
  logic [31:0]         out_highest_r;

  // Bitmap RAM.
  logic [7:0]          bitmap_mem [ROWS];
  logic [7:0]          rd_data_r;
  logic                mem_re;
  logic [ROW_W-1:0]    mem_ra;
  logic                mem_we;
  logic [ROW_W-1:0]    mem_wa;
  logic [7:0]          mem_wd;

  // ---------------------------------------------------------------------------------------
  // Shared combinational values
  // ---------------------------------------------------------------------------------------
  logic [31:0]         seq_mask;
  logic [31:0]         cur;
  logic [31:0]         diff;
  logic [31:0]         back;
  logic [SLOT_W-1:0]   mod_top;
  logic [7:0]          slot_bit;
  logic [ROW_W-1:0]    slot_row;
  logic [7:0]          row_data;
  logic [7:0]          op_wd;
  logic                in_take;
  logic                out_free;

  assign seq_mask = wide_r ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  assign cur      = highest_r & seq_mask;
  // Forward distance modulo the sequence space; covers the wrapped-ahead case too.
  assign diff     = (vm_r - cur) & seq_mask;
  assign back     = cur - vm_r;
  assign mod_top  = wide_r ? MOD_WIDE : MOD_NARROW;
  assign slot_bit = 8'd1 << slot_r[2:0];
  assign slot_row = ROW_W'(slot_r >> 3);
  assign row_data = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign op_wd    = (row_data & ~op_clr_r) | op_set_r;
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Remainder step: fold in the next four bits of the request number, most significant first.
  logic [3:0]          mod_nib;
  logic [MODX_W-1:0]   mod_x;
  logic [SLOT_W-1:0]   mod_rem;

  assign mod_nib = vm_r[{~digit_r, 2'b00} +: 4];
  assign mod_x   = {slot_r, mod_nib};

  always_comb begin
    mod_rem = SLOT_W'(mod_x);
    for (int k = 1; k < 16; k++) begin
      if (mod_x >= MODX_W'(k * STORE_BITS)) begin
        mod_rem = SLOT_W'(mod_x - MODX_W'(k * STORE_BITS));
      end
    end
  end

  // One clearing chunk: the run of bits from s_r downwards that stays within one row,
  // within the numbers left, and does not cross sequence number zero.
  logic [3:0]          c_top;
  logic [3:0]          c_n;
  logic [3:0]          c_p;
  logic [3:0]          c_k;
  logic                c_wrap;
  logic [8:0]          c_hi;
  logic [8:0]          c_lo;
  logic [7:0]          c_clr;

  always_comb begin
    c_top = {1'b0, s_r[2:0]} + 4'd1;
    c_n   = (32'(n_r) > 32'd8) ? 4'd8 : 4'(n_r);
    c_p   = (p_r < 32'd8) ? (4'(p_r) + 4'd1) : 4'd8;
    c_k   = c_top;
    if (c_n < c_k) begin
      c_k = c_n;
    end
    if (c_p < c_k) begin
      c_k = c_p;
    end
    c_wrap = (p_r < 32'd8) && (c_k == c_p);
    c_hi   = (9'd1 << c_top) - 9'd1;
    c_lo   = (9'd1 << (c_top - c_k)) - 9'd1;
    c_clr  = c_hi[7:0] & ~c_lo[7:0];
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    wide_nxt     = cfg_write_en ? cfg_write_data : wide_r;
    started_nxt  = started_r;
    highest_nxt  = highest_r;
    vm_nxt       = vm_r;
    rec_nxt      = rec_r;
    slot_nxt     = slot_r;
    digit_nxt    = digit_r;
    verdict_nxt  = verdict_r;
    sweep_nxt    = sweep_r;
    p_nxt        = p_r;
    s_nxt        = s_r;
    n_nxt        = n_r;
    op_v_nxt     = 1'b0;
    op_row_nxt   = op_row_r;
    op_clr_nxt   = op_clr_r;
    op_set_nxt   = op_set_r;
    mem_re       = 1'b0;
    mem_ra       = slot_row;

    case (state_r)
      ST_SWEEP: begin
        sweep_nxt = sweep_r + ROW_W'(1);
        if (sweep_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          vm_nxt    = in_sequence_req & seq_mask;
          rec_nxt   = in_action;
          digit_nxt = 3'd0;
          if (SLOT_POW2) begin
            slot_nxt  = SLOT_W'(in_sequence_req & seq_mask);
            state_nxt = ST_CLASS;
          end else begin
            slot_nxt  = '0;
            state_nxt = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        slot_nxt  = mod_rem;
        digit_nxt = digit_r + 3'd1;
        if (digit_r == 3'd7) begin
          state_nxt = ST_CLASS;
        end
      end

      ST_CLASS: begin
        state_nxt = ST_RESULT;
        if (!started_r) begin
          // Before the first record the bitmap is all clear, so setting one bit is enough.
          verdict_nxt = arwb_pkg::VERDICT_FIRST;
          if (rec_r) begin
            started_nxt = 1'b1;
            highest_nxt = vm_r;
            mem_re      = 1'b1;
            op_v_nxt    = 1'b1;
            op_row_nxt  = slot_row;
            op_clr_nxt  = 8'd0;
            op_set_nxt  = slot_bit;
          end
        end else if (diff == 32'd0) begin
          verdict_nxt = arwb_pkg::VERDICT_DUP;
        end else if (diff <= 32'(FWD_MAX)) begin
          verdict_nxt = arwb_pkg::VERDICT_AHEAD;
          if (rec_r) begin
            highest_nxt = vm_r;
            mem_re      = 1'b1;
            op_v_nxt    = 1'b1;
            op_row_nxt  = slot_row;
            op_clr_nxt  = 8'd0;
            op_set_nxt  = slot_bit;
            // Walker starts one number below the new highest.
            p_nxt = (vm_r == 32'd0) ? seq_mask : (vm_r - 32'd1);
            if (vm_r == 32'd0) begin
              s_nxt = mod_top;
            end else if (slot_r == '0) begin
              s_nxt = SLOT_LAST;
            end else begin
              s_nxt = slot_r - SLOT_W'(1);
            end
            n_nxt = CNT_W'(diff - 32'd1);
            if (diff != 32'd1) begin
              state_nxt = ST_CLEAR;
            end
          end
        end else if (vm_r > cur) begin
          verdict_nxt = arwb_pkg::VERDICT_FAR;
        end else if (back >= 32'(WINDOW_BITS)) begin
          verdict_nxt = arwb_pkg::VERDICT_OLD;
        end else begin
          // Inside the window: the bit decides. The row is written back with the bit set
          // only when recording; if it was already set the write changes nothing.
          mem_re     = 1'b1;
          op_v_nxt   = 1'b1;
          op_row_nxt = slot_row;
          op_clr_nxt = 8'd0;
          op_set_nxt = rec_r ? slot_bit : 8'd0;
          state_nxt  = ST_LOOK;
        end
      end

      ST_LOOK: begin
        verdict_nxt = ((row_data & slot_bit) != 8'd0) ? arwb_pkg::VERDICT_DUP
                                                       : arwb_pkg::VERDICT_NEW;
        state_nxt   = ST_RESULT;
      end

      ST_CLEAR: begin
        mem_re     = 1'b1;
        mem_ra     = ROW_W'(s_r >> 3);
        op_v_nxt   = 1'b1;
        op_row_nxt = ROW_W'(s_r >> 3);
        op_clr_nxt = c_clr;
        op_set_nxt = 8'd0;
        n_nxt      = n_r - CNT_W'(c_k);
        if (c_wrap) begin
          p_nxt = seq_mask;
          s_nxt = mod_top;
        end else begin
          p_nxt = p_r - 32'(c_k);
          s_nxt = (32'(s_r) < 32'(c_k)) ? SLOT_LAST : (s_r - SLOT_W'(c_k));
        end
        if (n_r == CNT_W'(c_k)) begin
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The row being written this cycle may be the one just read; its new value is kept.
  assign fwd_hit_nxt  = mem_re && op_v_r && (op_row_r == mem_ra);
  assign fwd_data_nxt = op_wd;

  // Write port: the reset sweep, else the write half of the pipeline.
  always_comb begin
    if (state_r == ST_SWEEP) begin
      mem_we = 1'b1;
      mem_wa = sweep_r;
      mem_wd = 8'd0;
    end else begin
      mem_we = op_v_r;
      mem_wa = op_row_r;
      mem_wd = op_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= bitmap_mem[mem_ra];
    end
  end

  // ---------------------------------------------------------------------------------------
  // State and control registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      wide_r      <= 1'b0;
      started_r   <= 1'b0;
      highest_r   <= 32'd0;
      op_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      wide_r    <= wide_nxt;
      started_r <= started_nxt;
      highest_r <= highest_nxt;
      op_v_r    <= op_v_nxt;
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    vm_r       <= vm_nxt;
    rec_r      <= rec_nxt;
    slot_r     <= slot_nxt;
    digit_r    <= digit_nxt;
    verdict_r  <= verdict_nxt;
    p_r        <= p_nxt;
    s_r        <= s_nxt;
    n_r        <= n_nxt;
    op_row_r   <= op_row_nxt;
    op_clr_r   <= op_clr_nxt;
    op_set_r   <= op_set_nxt;
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_data_r <= fwd_data_nxt;
    if (state_r == ST_RESULT && out_free) begin
      out_accepted_r <= arwb_pkg::verdict_ok(verdict_r);
      out_verdict_r  <= verdict_r;
      out_highest_r  <= highest_r & seq_mask;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_verdict      = out_verdict_r;
  assign out_highest_seen = out_highest_r;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  `ARWB_ASSERT_IMPLY(a_accept_matches_verdict, out_valid_r,
    out_accepted_r == ((out_verdict_r == arwb_pkg::VERDICT_FIRST) ||
    (out_verdict_r == arwb_pkg::VERDICT_AHEAD) || (out_verdict_r == arwb_pkg::VERDICT_NEW)),
    "accepted flag disagrees with verdict")
  `ARWB_ASSERT_IMPLY(a_clear_not_empty, state_r == ST_CLEAR, n_r != '0,
    "clearing walk entered with nothing left to clear")
  `ARWB_ASSERT_IMPLY(a_sweep_no_rmw, state_r == ST_SWEEP, !op_v_r,
    "row write pending during the reset sweep")
  `ARWB_ASSERT_NEVER(a_started_kept, $past(rst_n) && $fell(started_r),
    "started flag dropped outside reset")

endmodule
